[rtl/core/cmhs_pkg.sv]
package cmhs_pkg;

  localparam int ROWS_DEF      = 4;
  localparam int ROW_WIDTH_DEF = 1024;
  localparam int RANK_REGS_DEF = 1024;
  localparam int FIFO_DEPTH    = 4;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int CNT_W   = 32;
  localparam int UPD_W   = 64;
  localparam int IDX_W   = 10;
  localparam int RANK_W  = 6;
  localparam int HASH_W  = 32;
  localparam int IN_W    = ADDR_W + PORT_W;
  localparam int OUT_W   = CNT_W + CNT_W + UPD_W + IDX_W + RANK_W;

  localparam logic [HASH_W-1:0] MIX_MUL_A   = 32'h9e37_79b1;
  localparam logic [HASH_W-1:0] MIX_MUL_B   = 32'h85eb_ca77;
  localparam logic [HASH_W-1:0] RANK_SEED   = 32'h5bd1_e995;
  localparam logic [CNT_W-1:0]  COUNTER_MAX = 32'hffff_ffff;

  localparam logic [HASH_W-1:0] ROW_SEED [4] = '{
    32'h0000_0001, 32'h9e37_79b1, 32'h85eb_ca77, 32'hc2b2_ae3d
  };

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_MIN,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic init_done;
  } back_stat_t;

  // rank = leading zeros of (h >> 10) | 1, plus one
  function automatic logic [RANK_W-1:0] hll_rank(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] v;
    logic [RANK_W-1:0] n;
    logic              found;
    v     = (h >> 10) | 32'h1;
    n     = '0;
    found = 1'b0;
    for (int i = HASH_W - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          n = n + RANK_W'(1);
        end
      end
    end
    return n + RANK_W'(1);
  endfunction

endpackage

[rtl/core/cmhs_fifo.sv]
module cmhs_fifo
  import cmhs_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      fill_r, fill_nxt;
  logic             push, pop;

  assign wr_ready = (fill_r != (AW+1)'(DEPTH));
  assign rd_valid = (fill_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (AW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/cmhs_front.sv]
module cmhs_front
  import cmhs_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int ROW_WIDTH = ROW_WIDTH_DEF,
  parameter int RANK_REGS = RANK_REGS_DEF,
  localparam int CW       = $clog2(ROW_WIDTH),
  localparam int RW       = $clog2(RANK_REGS),
  localparam int EW       = ROWS * CW + RW + RANK_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] src_addr,
  input  logic [PORT_W-1:0] dst_port,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [EW-1:0]     q_data
);

  localparam int LANES = ROWS + 1;

  logic [HASH_W-1:0] x_r  [LANES];
  logic [HASH_W-1:0] m1_r [LANES];
  logic [HASH_W-1:0] m2_r [LANES];
  logic [HASH_W-1:0] h    [LANES];
  logic              v1_r, v2_r, v3_r;
  logic              adv1, adv2, adv3;
  logic              take;

  assign adv3     = !v3_r || q_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1 && enable;
  assign take     = in_valid && in_ready;
  assign q_valid  = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= take;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [HASH_W-1:0] key;
    logic [HASH_W-1:0] mix1;

    if (g < ROWS) begin : g_row
      assign key = src_addr ^ ROW_SEED[g];
    end else begin : g_rank
      assign key = src_addr ^ {dst_port, 16'h0000} ^ RANK_SEED;
    end

    assign mix1 = m1_r[g] ^ (m1_r[g] >> 15);
    assign h[g] = m2_r[g] ^ (m2_r[g] >> 13);

    always_ff @(posedge clk) begin
      if (adv1 && take) x_r[g]  <= key;
      if (adv2 && v1_r) m1_r[g] <= x_r[g] * MIX_MUL_A;
      if (adv3 && v2_r) m2_r[g] <= mix1 * MIX_MUL_B;
    end

    if (g < ROWS) begin : g_col
      assign q_data[g*CW +: CW] = h[g][CW-1:0];
    end
  end

  assign q_data[ROWS*CW +: RW]         = h[ROWS][RW-1:0];
  assign q_data[ROWS*CW + RW +: RANK_W] = hll_rank(h[ROWS]);

endmodule

[rtl/core/cmhs_back.sv]
module cmhs_back
  import cmhs_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int ROW_WIDTH = ROW_WIDTH_DEF,
  parameter int RANK_REGS = RANK_REGS_DEF,
  localparam int CW       = $clog2(ROW_WIDTH),
  localparam int RW       = $clog2(RANK_REGS),
  localparam int EW       = ROWS * CW + RW + RANK_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [EW-1:0]    q_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output back_stat_t       stat
);

  localparam int CLR_N = (ROW_WIDTH > RANK_REGS) ? ROW_WIDTH : RANK_REGS;
  localparam int CLR_W = $clog2(CLR_N);

  back_state_t       state_r, state_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic              clr_last, row_clr, rank_clr;
  logic              pop, out_load;
  logic [EW-1:0]     cur_r;
  logic [RW-1:0]     cur_sel;
  logic [RANK_W-1:0] cur_rank;

  logic [CNT_W-1:0]  rd_r  [ROWS];
  logic [CNT_W-1:0]  inc_w [ROWS];
  logic [CNT_W-1:0]  inc_r [ROWS];
  logic [RANK_W-1:0] rank_mem [RANK_REGS];
  logic [RANK_W-1:0] rank_rd_r;
  logic [RANK_W-1:0] rank_new_r;
  logic              rank_we;
  logic [RW-1:0]     rank_waddr;
  logic [RANK_W-1:0] rank_wdata;
  logic [CNT_W-1:0]  est_w;
  logic [CNT_W-1:0]  est_r;
  logic [CNT_W-1:0]  largest_r, largest_nxt;
  logic [UPD_W-1:0]  count_r, count_nxt;
  logic              out_tvalid_r;
  logic [CNT_W-1:0]  out_est_r, out_hh_r;
  logic [UPD_W-1:0]  out_cnt_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [RANK_W-1:0] out_rank_r;

  assign cur_sel  = cur_r[ROWS*CW +: RW];
  assign cur_rank = cur_r[ROWS*CW + RW +: RANK_W];
  assign clr_last = (clr_r == CLR_W'(CLR_N - 1));
  assign row_clr  = ({1'b0, clr_r} < (CLR_W+1)'(ROW_WIDTH));
  assign rank_clr = ({1'b0, clr_r} < (CLR_W+1)'(RANK_REGS));
  assign pop      = (state_r == BK_IDLE) && q_valid;
  assign q_ready  = (state_r == BK_IDLE);
  assign out_load = (state_r == BK_OUT) && (!out_tvalid_r || out_tready);

  assign stat.init_done = (state_r != BK_CLEAR);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      BK_CLEAR: begin
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) state_nxt = BK_READ;
      end
      BK_READ:  state_nxt = BK_MIN;
      BK_MIN:   state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_load) state_nxt = BK_IDLE;
      end
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // counter rows: one memory per row, read on pop, written back in BK_READ
  for (genvar g = 0; g < ROWS; g++) begin : g_row
    logic [CNT_W-1:0] mem [ROW_WIDTH];
    logic             we;
    logic [CW-1:0]    waddr;
    logic [CNT_W-1:0] wdata;

    assign inc_w[g] = (rd_r[g] == COUNTER_MAX) ? rd_r[g] : rd_r[g] + CNT_W'(1);
    assign we       = ((state_r == BK_CLEAR) && row_clr) || (state_r == BK_READ);
    assign waddr    = (state_r == BK_CLEAR) ? clr_r[CW-1:0] : cur_r[g*CW +: CW];
    assign wdata    = (state_r == BK_CLEAR) ? '0 : inc_w[g];

    always_ff @(posedge clk) begin
      if (we) mem[waddr] <= wdata;
      if (pop) rd_r[g] <= mem[q_data[g*CW +: CW]];
      if (state_r == BK_READ) inc_r[g] <= inc_w[g];
    end
  end

  assign rank_we    = ((state_r == BK_CLEAR) && rank_clr) ||
                      ((state_r == BK_READ) && (cur_rank > rank_rd_r));
  assign rank_waddr = (state_r == BK_CLEAR) ? clr_r[RW-1:0] : cur_sel;
  assign rank_wdata = (state_r == BK_CLEAR) ? '0 : cur_rank;

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
    if (pop) begin
      rank_rd_r <= rank_mem[q_data[ROWS*CW +: RW]];
      cur_r     <= q_data;
    end
    if (state_r == BK_READ) begin
      rank_new_r <= (cur_rank > rank_rd_r) ? cur_rank : rank_rd_r;
    end
    if (state_r == BK_MIN) est_r <= est_w;
  end

  always_comb begin
    est_w = COUNTER_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (inc_r[r] < est_w) est_w = inc_r[r];
    end
  end

  assign largest_nxt = (est_r > largest_r) ? est_r : largest_r;
  assign count_nxt   = count_r + UPD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_r    <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        largest_r    <= largest_nxt;
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_est_r  <= est_r;
      out_hh_r   <= largest_nxt;
      out_cnt_r  <= count_nxt;
      out_idx_r  <= IDX_W'(cur_sel);
      out_rank_r <= rank_new_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_rank_r, out_idx_r, out_cnt_r, out_hh_r, out_est_r};

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("result load did not raise out_tvalid");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == $past(count_r) + UPD_W'(1)))
    else $error("update count did not advance by one");

  a_est_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_est_r <= out_hh_r))
    else $error("estimate above heavy-hitter maximum");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ((out_rank_r >= RANK_W'(11)) && (out_rank_r <= RANK_W'(32))))
    else $error("fanout rank out of range");
`endif

endmodule

[rtl/core/count_min_hll_sketch_update_unit.sv]
// Count-min sketch update with a HyperLogLog fan-out register file. Each
// packet (source address, destination port) is hashed in a three-stage front
// pipeline into one counter column per row and one rank register, queued, and
// applied by a back end that reads, increments (saturating), takes the
// minimum and loads the result register. The back end takes no new packet
// until the last one has left BK_OUT, as the counter and rank memories are
// single-ported and updated by a read-modify-write sequence. After reset the
// memories are swept to zero, and in_tready stays low until the sweep is done.
module count_min_hll_sketch_update_unit
  import cmhs_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int ROW_WIDTH = ROW_WIDTH_DEF,
  parameter int RANK_REGS = RANK_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // src_addr[31:0], dst_port[47:32]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // count_estimate[31:0], heavy_hitter_max[63:32],
                                       // update_count[127:64], fanout_index[137:128],
                                       // fanout_rank[143:138]
);

  localparam int CW = $clog2(ROW_WIDTH);
  localparam int RW = $clog2(RANK_REGS);
  localparam int EW = ROWS * CW + RW + RANK_W;

  logic          fq_valid, fq_ready;
  logic [EW-1:0] fq_data;
  logic          bq_valid, bq_ready;
  logic [EW-1:0] bq_data;
  back_stat_t    bstat;

  cmhs_front #(
    .ROWS      (ROWS),
    .ROW_WIDTH (ROW_WIDTH),
    .RANK_REGS (RANK_REGS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (bstat.init_done),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .src_addr (in_tdata[ADDR_W-1:0]),
    .dst_port (in_tdata[ADDR_W +: PORT_W]),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  cmhs_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (EW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  cmhs_back #(
    .ROWS      (ROWS),
    .ROW_WIDTH (ROW_WIDTH),
    .RANK_REGS (RANK_REGS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_data     (bq_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (bstat)
  );

endmodule

[verif/testbench.sv]
module testbench
  import cmhs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int FIRST_BATCH = 700;
  localparam int SECOND_BATCH = 800;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } packet_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  idx;
    logic [UPD_W-1:0]  upd;
    logic [CNT_W-1:0]  hmax;
    logic [CNT_W-1:0]  est;
  } sketch_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  packet_t        packet_q[$];
  sketch_result_t result_q[$];
  packet_t        drv_pkt;

  logic [CNT_W-1:0]  row_cnt [ROWS_DEF][ROW_WIDTH_DEF];
  logic [RANK_W-1:0] rank_reg [RANK_REGS_DEF];
  logic [CNT_W-1:0]  top_estimate;
  logic [UPD_W-1:0]  updates_done;

  int errors = 0;
  int burst_left, gap_left;
  int rx_mode, rx_phase_left, rx_hold_left, rx_taken;
  int stall_cycles;

  count_min_hll_sketch_update_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] mix32(logic [HASH_W-1:0] v, logic [HASH_W-1:0] seed);
    v = v ^ seed;
    v = v * MIX_MUL_A;
    v = v ^ (v >> 15);
    v = v * MIX_MUL_B;
    v = v ^ (v >> 13);
    return v;
  endfunction

  // address whose fan-out hash with this port comes out as h
  function automatic logic [ADDR_W-1:0] addr_for_fanout(logic [HASH_W-1:0] h,
                                                        logic [PORT_W-1:0] port);
    logic [HASH_W-1:0] v, inv_a, inv_b;
    inv_a = MIX_MUL_A;
    inv_b = MIX_MUL_B;
    repeat (5) begin
      inv_a = inv_a * (32'd2 - MIX_MUL_A * inv_a);
      inv_b = inv_b * (32'd2 - MIX_MUL_B * inv_b);
    end
    v = h ^ (h >> 13) ^ (h >> 26);
    v = v * inv_b;
    v = v ^ (v >> 15) ^ (v >> 30);
    v = v * inv_a;
    return v ^ RANK_SEED ^ {port, 16'h0000};
  endfunction

  function automatic void predict_update(packet_t p);
    sketch_result_t    r;
    logic [HASH_W-1:0] h, probe;
    logic [CNT_W-1:0]  v;
    int                col, lz;
    r.est = COUNTER_MAX;
    for (int row = 0; row < ROWS_DEF; row++) begin
      col = int'(mix32(p.addr, ROW_SEED[row]) & (ROW_WIDTH_DEF - 1));
      v = row_cnt[row][col];
      if (v != COUNTER_MAX) v = v + 1;
      row_cnt[row][col] = v;
      if (v < r.est) r.est = v;
    end
    h = mix32(p.addr ^ {p.port, 16'h0000}, RANK_SEED);
    r.idx = h[IDX_W-1:0];
    probe = (h >> 10) | 32'h1;
    lz = 0;
    while (!probe[31]) begin
      probe = probe << 1;
      lz++;
    end
    if (RANK_W'(lz + 1) > rank_reg[r.idx]) rank_reg[r.idx] = RANK_W'(lz + 1);
    r.rank = rank_reg[r.idx];
    updates_done = updates_done + 1;
    if (r.est > top_estimate) top_estimate = r.est;
    r.hmax = top_estimate;
    r.upd = updates_done;
    result_q.push_back(r);
  endfunction

  function automatic void report(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endfunction

  function automatic void push_pkt(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
    packet_t p;
    p.addr = addr;
    p.port = port;
    packet_q.push_back(p);
  endfunction

  function automatic void push_random(int n, ref logic [ADDR_W-1:0] hot[8]);
    int                sel;
    logic [PORT_W-1:0] port;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      port = PORT_W'($urandom);
      if (sel < 40)
        push_pkt(hot[$urandom_range(0, 7)], port);
      else if (sel < 55)
        push_pkt(addr_for_fanout($urandom >> $urandom_range(0, 31), port), port);
      else
        push_pkt($urandom, port);
    end
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (packet_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        drv_pkt = packet_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= drv_pkt;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern plus long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode <= 0;
      rx_phase_left <= 0;
      rx_hold_left <= 0;
      rx_taken <= 0;
    end else begin
      if (out_tvalid && out_tready) rx_taken <= rx_taken + 1;
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && (rx_taken == 149 || rx_taken == 999)) begin
        rx_hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode <= $urandom_range(0, 2);
          rx_phase_left <= $urandom_range(8, 80);
        end else begin
          rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    sketch_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_update(packet_t'(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %0h", $time, out_tdata);
        end else begin
          want = result_q.pop_front();
          if (got.est !== want.est)
            report("count_estimate", 64'(want.est), 64'(got.est));
          if (got.hmax !== want.hmax)
            report("heavy_hitter_max", 64'(want.hmax), 64'(got.hmax));
          if (got.upd !== want.upd)
            report("update_count", want.upd, got.upd);
          if (got.idx !== want.idx)
            report("fanout_index", 64'(want.idx), 64'(got.idx));
          if (got.rank !== want.rank)
            report("fanout_rank", 64'(want.rank), 64'(got.rank));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] hot[8];
    for (int row = 0; row < ROWS_DEF; row++)
      for (int c = 0; c < ROW_WIDTH_DEF; c++) row_cnt[row][c] = '0;
    for (int i = 0; i < RANK_REGS_DEF; i++) rank_reg[i] = '0;
    top_estimate = '0;
    updates_done = '0;
    for (int i = 0; i < 8; i++) hot[i] = $urandom;

    // field extremes
    push_pkt(32'h0000_0000, 16'h0000);
    push_pkt(32'hffff_ffff, 16'hffff);
    push_pkt(32'h0000_0000, 16'hffff);
    push_pkt(32'hffff_ffff, 16'h0000);
    // same source back to back
    repeat (6) push_pkt(32'h0a00_0001, 16'h0050);
    // extreme ranks and registers
    push_pkt(addr_for_fanout(32'h0000_03ff, 16'h1234), 16'h1234);
    push_pkt(addr_for_fanout(32'h0000_0000, 16'h0000), 16'h0000);
    push_pkt(addr_for_fanout(32'h8000_0155, 16'h01bb), 16'h01bb);
    push_pkt(addr_for_fanout(32'h0000_0155, 16'h0016), 16'h0016);
    push_pkt(addr_for_fanout(32'h8000_0155, 16'h0035), 16'h0035);
    // alternating sources
    repeat (2) begin
      push_pkt(32'h0a00_0001, 16'h0050);
      push_pkt(32'hc0a8_0101, 16'h0050);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_random(FIRST_BATCH, hot);
    // sender pause until everything is back
    do @(negedge clk); while (packet_q.size() != 0 || in_tvalid || result_q.size() != 0);
    push_random(SECOND_BATCH, hot);
    do @(negedge clk); while (packet_q.size() != 0 || in_tvalid || result_q.size() != 0);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
